@@ sv/srfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply frame parser package
// Shared constants, register indexes, parser phases and the result word type.
// ----------------------------------------------------------------------------
package srfp_pkg;

   // Frame layout
   localparam logic [7:0] DEV_ADDR_RESET    = 8'h81;
   localparam logic [7:0] CMD_FIRST         = 8'h11;
   localparam logic [7:0] CMD_LAST_AVG      = 8'h13;
   localparam logic [7:0] CMD_TH            = 8'h14;
   localparam logic [7:0] CMD_STATE         = 8'h16;
   localparam logic [3:0] AVG_PAYLOAD_BYTES = 4'd12;
   localparam logic [3:0] TH_PAYLOAD_BYTES  = 4'd4;
   localparam int         NUM_VALUES        = 6;

   // Command index codes (command byte minus the first command)
   localparam logic [2:0] IDX_AVG_LAST = 3'd2;
   localparam logic [2:0] IDX_TH       = 3'd3;
   localparam logic [2:0] IDX_STATE    = 3'd5;

   // Register indexes of the configuration port
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_SAMPLING_ON    = 1'b1;

   // Word widths
   localparam int RSP_TDATA_W = 112;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_STATUS,
      PH_PAYLOAD,
      PH_CHECK
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]  command_index;
      logic [7:0]  sensor_status;
      logic [15:0] value_0;
      logic [15:0] value_1;
      logic [15:0] value_2;
      logic [15:0] value_3;
      logic [15:0] value_4;
      logic [15:0] value_5;
      logic        ask_power_toggle;
      logic        ask_temp_humidity;
      logic        device_found;
   } srfp_result_type;

endpackage

@@ sv/srfp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply frame parser
// Tracks the frame phase, the running checksum and the payload bytes, and
// builds the result word when the check byte of a frame matches.
// ----------------------------------------------------------------------------
module srfp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                rx_byte,
   input  logic [7:0]                device_address,
   input  logic                      sampling_on,
   output logic                      res_valid,
   output srfp_pkg::srfp_result_type res_word
);

   srfp_pkg::parse_phase_type phase_ff, phase_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [7:0] status_ff, status_in;
   logic [3:0] len_ff, len_in;
   logic [3:0] offset_ff, offset_in;
   logic [7:0] sum_ff, sum_in;
   logic       found_ff, found_in;
   logic [7:0] store_ff [srfp_pkg::AVG_PAYLOAD_BYTES];

   logic [3:0]  offset_next;
   logic [7:0]  sum_next;
   logic        cmd_ok;
   logic        check_ok;
   logic [15:0] words [srfp_pkg::NUM_VALUES];
   logic        is_avg;
   logic        toggle;

   assign offset_next = offset_ff + 4'd1;
   assign sum_next    = sum_ff + rx_byte;
   assign cmd_ok      = (rx_byte inside {[srfp_pkg::CMD_FIRST : srfp_pkg::CMD_STATE]});
   assign check_ok    = (sum_next == 8'd0);
   assign is_avg      = (cmd_ff <= srfp_pkg::IDX_AVG_LAST);
   assign toggle      = (status_ff[0] == sampling_on);

   // Big-endian payload words
   always_comb begin
      for (int i = 0; i < srfp_pkg::NUM_VALUES; i++) begin
         words[i] = {store_ff[2 * i], store_ff[2 * i + 1]};
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         case (phase_ff)
            srfp_pkg::PH_IDLE: begin
               if (rx_byte == device_address) phase_in = srfp_pkg::PH_ADDR;
            end
            srfp_pkg::PH_ADDR: begin
               phase_in = cmd_ok ? srfp_pkg::PH_STATUS : srfp_pkg::PH_IDLE;
            end
            srfp_pkg::PH_STATUS: begin
               phase_in = (len_ff == 4'd0) ? srfp_pkg::PH_CHECK : srfp_pkg::PH_PAYLOAD;
            end
            srfp_pkg::PH_PAYLOAD: begin
               if (offset_next >= len_ff) phase_in = srfp_pkg::PH_CHECK;
            end
            default: phase_in = srfp_pkg::PH_IDLE;
         endcase
      end
   end

   // Frame fields, checksum and result
   always_comb begin
      cmd_in    = cmd_ff;
      status_in = status_ff;
      len_in    = len_ff;
      offset_in = offset_ff;
      sum_in    = sum_ff;
      found_in  = found_ff;
      res_valid = 1'b0;
      res_word  = '0;
      res_word.command_index = cmd_ff;
      res_word.sensor_status = status_ff;
      if (byte_valid) begin
         case (phase_ff)
            srfp_pkg::PH_IDLE: begin
               if (rx_byte == device_address) sum_in = rx_byte;
            end
            srfp_pkg::PH_ADDR: begin
               if (cmd_ok) begin
                  cmd_in = 3'(rx_byte - srfp_pkg::CMD_FIRST);
                  sum_in = sum_next;
                  if (rx_byte <= srfp_pkg::CMD_LAST_AVG) begin
                     len_in = srfp_pkg::AVG_PAYLOAD_BYTES;
                  end else if (rx_byte == srfp_pkg::CMD_TH) begin
                     len_in = srfp_pkg::TH_PAYLOAD_BYTES;
                  end else begin
                     len_in = 4'd0;
                  end
               end
            end
            srfp_pkg::PH_STATUS: begin
               status_in = rx_byte;
               sum_in    = sum_next;
               offset_in = 4'd0;
            end
            srfp_pkg::PH_PAYLOAD: begin
               sum_in    = sum_next;
               offset_in = offset_next;
            end
            srfp_pkg::PH_CHECK: begin
               if (check_ok) begin
                  res_valid = 1'b1;
                  if (is_avg) begin
                     res_word.value_0           = words[0];
                     res_word.value_1           = words[1];
                     res_word.value_2           = words[2];
                     res_word.value_3           = words[3];
                     res_word.value_4           = words[4];
                     res_word.value_5           = words[5];
                     res_word.ask_power_toggle  = toggle;
                     res_word.ask_temp_humidity = 1'b1;
                     found_in                   = 1'b1;
                  end else if (cmd_ff == srfp_pkg::IDX_TH) begin
                     res_word.value_0 = words[0];
                     res_word.value_1 = words[1];
                  end else if (cmd_ff == srfp_pkg::IDX_STATE) begin
                     res_word.ask_power_toggle = toggle;
                     found_in                  = 1'b1;
                  end
                  res_word.device_found = found_in;
               end
            end
            default: ;
         endcase
      end
   end

   // Control and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= srfp_pkg::PH_IDLE;
         cmd_ff    <= 3'd0;
         status_ff <= 8'd0;
         len_ff    <= 4'd0;
         offset_ff <= 4'd0;
         sum_ff    <= 8'd0;
         found_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
         found_ff  <= found_in;
      end
   end

   // Payload bytes, written in arrival order
   always_ff @(posedge clock) begin
      if (byte_valid && (phase_ff == srfp_pkg::PH_PAYLOAD) &&
          (offset_ff < srfp_pkg::AVG_PAYLOAD_BYTES)) begin
         store_ff[offset_ff] <= rx_byte;
      end
   end

endmodule

@@ sv/srfp_result_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result word for the output channel; it is refilled in the same
// cycle in which the receiver takes the word it holds.
// ----------------------------------------------------------------------------
module srfp_result_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  srfp_pkg::srfp_result_type in_word,
   output logic                      in_ready,
   output logic                      out_valid,
   output srfp_pkg::srfp_result_type out_word,
   input  logic                      out_ready
);

   logic                      valid_ff, valid_in;
   srfp_pkg::srfp_result_type word_ff;

   // Free when empty or when the held word leaves this cycle.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
      end
   end

endmodule

@@ sv/sensor_reply_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply frame parser
// Parses sensor reply frames from a byte stream and checks their checksum.
// ----------------------------------------------------------------------------
// Usage:
// Received serial bytes enter on the req_ channel, one word per byte. The
// parser hunts for the device address, then takes a command, a status byte,
// a payload and a check byte. Each frame whose check byte matches gives one
// word on the rsp_ channel; all other bytes give none.
// Throughput is one byte per cycle while req_tready is high. The result of a frame's check byte is
// valid on rsp_ in the cycle after that byte is accepted.
// The rate is set by the single result register: a byte is taken whenever
// that register is empty or its word is taken in the same cycle, so req_tready
// falls only while a result waits and rsp_tready is low.
// The csr_ port sets the device address (index 0) and the sampling mode
// (index 1); write it only while the parser is idle.
// Reset clears the parser to hunting, empties the result register, sets the
// address to 0x81 and sampling off, and clears the device-found flag.
// ----------------------------------------------------------------------------
module sensor_reply_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   // Received bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] rx_byte
   // Parsed frames
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] sensor_status, [23:8] value_0, [39:24] value_1, [55:40] value_2,
   // [71:56] value_3, [87:72] value_4, [103:88] value_5, [104] ask_power_toggle,
   // [105] ask_temp_humidity, [106] device_found, [111:107] zero
   output logic [srfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [srfp_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [2:0] command_index
   // Configuration
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [7:0]                       csr_wdata
);

   logic [7:0] dev_addr_ff;
   logic       sampling_ff;
   logic       byte_valid;
   logic       res_valid;
   logic       res_ready;
   srfp_pkg::srfp_result_type res_word;
   srfp_pkg::srfp_result_type out_word;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= srfp_pkg::DEV_ADDR_RESET;
         sampling_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            srfp_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_wdata;
            srfp_pkg::CSR_SAMPLING_ON:    sampling_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = res_ready;
   assign byte_valid = req_tvalid && res_ready;

   srfp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (byte_valid),
      .rx_byte        (req_tdata),
      .device_address (dev_addr_ff),
      .sampling_on    (sampling_ff),
      .res_valid      (res_valid),
      .res_word       (res_word)
   );

   srfp_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_word   (res_word),
      .in_ready  (res_ready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .out_ready (rsp_tready)
   );

   // Output word packing
   assign rsp_tuser = out_word.command_index;
   assign rsp_tdata = {5'd0,
                       out_word.device_found,
                       out_word.ask_temp_humidity,
                       out_word.ask_power_toggle,
                       out_word.value_5,
                       out_word.value_4,
                       out_word.value_3,
                       out_word.value_2,
                       out_word.value_1,
                       out_word.value_0,
                       out_word.sensor_status};

endmodule
